// ===== design/oled_page_transpose_framer_defines.svh =====
// Assertion macros shared by the page framer design.
`ifndef OLED_PAGE_TRANSPOSE_FRAMER_DEFINES_SVH
`define OLED_PAGE_TRANSPOSE_FRAMER_DEFINES_SVH

// Check that a condition implies another at the same edge.
`define OPTF_ASSERT_IMPLIES(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Check that a condition implies another at the next edge.
`define OPTF_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

// ===== design/optf_pkg.sv =====
// Shared types, constants and header helpers of the page framer.
`timescale 1ns / 1ps
package optf_pkg;

  localparam int COLUMNS_DEFAULT = 128;
  localparam int ROWS_DEFAULT = 64;
  localparam int CMD_DEPTH_DEFAULT = 4;
  localparam int COLUMNS_MAX = 128;
  localparam int WORD_MAX_W = $clog2((COLUMNS_MAX + 7) / 8);

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_PULL = 1'b1;

  localparam logic REG_PANEL_TYPE = 1'b0;
  localparam logic REG_DEVICE_ADDRESS = 1'b1;

  localparam logic [1:0] PANEL_BASIC = 2'd0;
  localparam logic [1:0] PANEL_COLRESET = 2'd1;
  localparam logic [1:0] PANEL_PADDED = 2'd2;

  localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'h3C;
  localparam logic [7:0] CTRL_BYTE = 8'h80;
  localparam logic [7:0] PAGE_BASE = 8'hB0;
  localparam logic [7:0] DATA_PREFIX = 8'h40;
  localparam logic [7:0] COL_LOW = 8'h00;
  localparam logic [7:0] COL_HIGH = 8'h10;
  localparam logic [7:0] PAD_BYTE = 8'h00;

  typedef enum logic [2:0] {
    CMD_LOAD,
    CMD_REFUSE,
    CMD_IDLE,
    CMD_HEADER,
    CMD_COLUMN
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [7:0]            data;
    logic                  start;
    logic                  last;
    logic [WORD_MAX_W-1:0] word;
    logic [2:0]            lane;
    logic [7:0]            row_mask;
  } cmd_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       tx_start;
    logic       tx_last;
    logic       load_refused;
  } res_t;

  function automatic logic [3:0] header_len(logic [1:0] panel);
    logic [3:0] len;
    case (panel)
      PANEL_COLRESET: len = 4'd8;
      PANEL_PADDED:   len = 4'd10;
      default:        len = 4'd4;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] header_byte(logic [1:0] panel, logic [6:0] addr,
                                             logic [2:0] page, logic [3:0] pos);
    logic       ext;
    logic [7:0] b;
    ext = (panel == PANEL_COLRESET) || (panel == PANEL_PADDED);
    case (pos)
      4'd0:    b = {addr, 1'b0};
      4'd1:    b = CTRL_BYTE;
      4'd2:    b = PAGE_BASE | {5'd0, page};
      4'd3:    b = ext ? CTRL_BYTE : DATA_PREFIX;
      4'd4:    b = COL_LOW;
      4'd5:    b = CTRL_BYTE;
      4'd6:    b = COL_HIGH;
      4'd7:    b = DATA_PREFIX;
      default: b = PAD_BYTE;
    endcase
    return b;
  endfunction

endpackage

// ===== design/optf_cmd_queue.sv =====
// Command queue between the front classifier and the back executor.
`timescale 1ns / 1ps
module optf_cmd_queue #(
  parameter int DEPTH = optf_pkg::CMD_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  optf_pkg::cmd_t wr_cmd,
  output logic          full,
  input  logic          rd_en,
  output optf_pkg::cmd_t rd_cmd,
  output logic          valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  optf_pkg::cmd_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full = (count == CNT_W'(DEPTH));
  assign valid = (count != '0);
  assign rd_cmd = entries[rd_ptr];
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/optf_front.sv =====
// Front part: accepts items, keeps the row and send counters and the config registers, and classifies.
`timescale 1ns / 1ps
module optf_front #(
  parameter int COLUMNS = optf_pkg::COLUMNS_DEFAULT,
  parameter int ROWS = optf_pkg::ROWS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  logic           kind,
  input  logic [7:0]     pixel_byte,
  input  logic           cmd_full,
  output logic           cmd_push,
  output optf_pkg::cmd_t cmd,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [6:0]     cfg_data
);

  localparam int BPR = (COLUMNS + 7) / 8;
  localparam int WORD_W = (BPR > 1) ? $clog2(BPR) : 1;
  localparam int ROW_W = $clog2(ROWS);

  logic [1:0]       panel_type;
  logic [6:0]       device_address;
  logic [WORD_W-1:0] byte_column;
  logic [WORD_W-1:0] byte_column_next;
  logic [ROW_W-1:0] row_index;
  logic [ROW_W-1:0] row_index_next;
  logic             page_pending;
  logic             page_pending_next;
  logic [7:0]       send_position;
  logic [7:0]       send_position_next;
  logic [2:0]       pending_page;
  logic [2:0]       pending_page_next;

  logic [3:0] hlen;
  logic [7:0] total_m1;
  logic [7:0] pos;
  logic [7:0] col;

  assign cmd_push = push && !cmd_full;

  always_comb begin
    hlen = optf_pkg::header_len(panel_type);
    total_m1 = 8'(COLUMNS) + {4'd0, hlen} - 8'd1;
    pos = (send_position > total_m1) ? total_m1 : send_position;
    col = pos - {4'd0, hlen};

    byte_column_next = byte_column;
    row_index_next = row_index;
    page_pending_next = page_pending;
    send_position_next = send_position;
    pending_page_next = pending_page;

    cmd = '0;
    cmd.kind = optf_pkg::CMD_IDLE;

    if (kind == optf_pkg::KIND_LOAD) begin
      if (page_pending) begin
        cmd.kind = optf_pkg::CMD_REFUSE;
      end else begin
        cmd.kind = optf_pkg::CMD_LOAD;
        cmd.data = pixel_byte;
        cmd.word = optf_pkg::WORD_MAX_W'(byte_column);
        cmd.lane = row_index[2:0];
        if (byte_column == WORD_W'(BPR - 1)) begin
          byte_column_next = '0;
          if ((row_index[2:0] == 3'd7) || (row_index == ROW_W'(ROWS - 1))) begin
            page_pending_next = 1'b1;
            pending_page_next = 3'(row_index >> 3);
            send_position_next = '0;
          end
          row_index_next = (row_index == ROW_W'(ROWS - 1)) ? '0 : row_index + 1'b1;
        end else begin
          byte_column_next = byte_column + 1'b1;
        end
      end
    end else if (page_pending) begin
      if (pos < {4'd0, hlen}) begin
        cmd.kind = optf_pkg::CMD_HEADER;
        cmd.data = optf_pkg::header_byte(panel_type, device_address, pending_page,
                                         pos[3:0]);
        cmd.start = (pos == 8'd0);
      end else begin
        cmd.kind = optf_pkg::CMD_COLUMN;
        cmd.word = optf_pkg::WORD_MAX_W'(col >> 3);
        cmd.lane = col[2:0];
        for (int r = 0; r < 8; r++) begin
          cmd.row_mask[r] = ({1'b0, pending_page, 3'(r)} < 7'(ROWS));
        end
      end
      if (pos == total_m1) begin
        cmd.last = 1'b1;
        page_pending_next = 1'b0;
        send_position_next = '0;
      end else begin
        send_position_next = pos + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_column <= '0;
      row_index <= '0;
      page_pending <= 1'b0;
      send_position <= '0;
      pending_page <= '0;
    end else if (cmd_push) begin
      byte_column <= byte_column_next;
      row_index <= row_index_next;
      page_pending <= page_pending_next;
      send_position <= send_position_next;
      pending_page <= pending_page_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      panel_type <= optf_pkg::PANEL_BASIC;
      device_address <= optf_pkg::DEVICE_ADDRESS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        optf_pkg::REG_PANEL_TYPE:     panel_type <= cfg_data[1:0];
        optf_pkg::REG_DEVICE_ADDRESS: device_address <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== design/optf_back.sv =====
// Back part: page store writes and column reads, and the result queue.
`timescale 1ns / 1ps
module optf_back #(
  parameter int COLUMNS = optf_pkg::COLUMNS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  optf_pkg::cmd_t q_cmd,
  output logic           q_pop,
  input  logic           pop,
  output logic           empty,
  output optf_pkg::res_t head
);

  localparam int BPR = (COLUMNS + 7) / 8;
  localparam int WORD_W = (BPR > 1) ? $clog2(BPR) : 1;

  logic [63:0]     store [BPR];
  logic [63:0]     rd_data;
  logic            s1_valid;
  optf_pkg::cmd_t  s1_cmd;
  optf_pkg::res_t  res;
  optf_pkg::res_t  outq [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            pop_fire;
  logic [2:0]      occ;
  logic [WORD_W-1:0] addr;

  assign pop_fire = pop && !empty;
  assign empty = (count == 2'd0);
  assign head = outq[rd_ptr];
  assign occ = {1'b0, count} + {2'd0, s1_valid} - {2'd0, pop_fire};
  assign q_pop = q_valid && (occ < 3'd2);
  assign addr = q_cmd.word[WORD_W-1:0];

  always_ff @(posedge clk) begin
    if (q_pop && (q_cmd.kind == optf_pkg::CMD_LOAD)) begin
      store[addr][{q_cmd.lane, 3'b000} +: 8] <= q_cmd.data;
    end
    if (q_pop) begin
      rd_data <= store[addr];
      s1_cmd <= q_cmd;
    end
  end

  always_comb begin
    res = '0;
    case (s1_cmd.kind)
      optf_pkg::CMD_REFUSE: res.load_refused = 1'b1;
      optf_pkg::CMD_HEADER: begin
        res.tx_byte = s1_cmd.data;
        res.tx_valid = 1'b1;
        res.tx_start = s1_cmd.start;
        res.tx_last = s1_cmd.last;
      end
      optf_pkg::CMD_COLUMN: begin
        for (int r = 0; r < 8; r++) begin
          res.tx_byte[r] = s1_cmd.row_mask[r] & rd_data[{3'(r), s1_cmd.lane}];
        end
        res.tx_valid = 1'b1;
        res.tx_last = s1_cmd.last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      outq[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      s1_valid <= q_pop;
      if (s1_valid) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_fire) begin
        rd_ptr <= ~rd_ptr;
      end
      if (s1_valid && !pop_fire) begin
        count <= count + 2'd1;
      end else if (pop_fire && !s1_valid) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== design/oled_page_transpose_framer.sv =====
// Top level of the page framer: front, command queue and back.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------------
//   input    | push / full          | kind, pixel_byte
//   result   | empty / pop          | tx_byte, tx_valid, tx_start, tx_last, load_refused
//   config   | cfg_we               | cfg_index, cfg_data
//
// One item per cycle in and one result per cycle out when both sides keep up.
// An item reaches the result ports through the command queue, then the page store
// read register, then the result queue.
// The page store needs no clearing pass: each page rewrites every row it sends.
// Reset clears counters and queues and sets the config registers to their defaults.
// A stalled result side fills the result and command queues, then raises full.
`timescale 1ns / 1ps
`include "oled_page_transpose_framer_defines.svh"
module oled_page_transpose_framer #(
  parameter int COLUMNS = optf_pkg::COLUMNS_DEFAULT,
  parameter int ROWS = optf_pkg::ROWS_DEFAULT,
  parameter int CMD_DEPTH = optf_pkg::CMD_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       kind,
  input  logic [7:0] pixel_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] tx_byte,
  output logic       tx_valid,
  output logic       tx_start,
  output logic       tx_last,
  output logic       load_refused,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data
);

  optf_pkg::cmd_t front_cmd;
  optf_pkg::cmd_t back_cmd;
  optf_pkg::res_t head;
  logic           front_push;
  logic           q_valid;
  logic           q_pop;

  optf_front #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .push(push),
    .kind(kind),
    .pixel_byte(pixel_byte),
    .cmd_full(full),
    .cmd_push(front_push),
    .cmd(front_cmd),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  optf_cmd_queue #(
    .DEPTH(CMD_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .wr_en(front_push),
    .wr_cmd(front_cmd),
    .full(full),
    .rd_en(q_pop),
    .rd_cmd(back_cmd),
    .valid(q_valid)
  );

  optf_back #(
    .COLUMNS(COLUMNS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_cmd(back_cmd),
    .q_pop(q_pop),
    .pop(pop),
    .empty(empty),
    .head(head)
  );

  assign tx_byte = head.tx_byte;
  assign tx_valid = head.tx_valid;
  assign tx_start = head.tx_start;
  assign tx_last = head.tx_last;
  assign load_refused = head.load_refused;

  `OPTF_ASSERT_IMPLIES(a_last_valid, clk, rst, !empty && tx_last, tx_valid && !tx_start, "stop on a non-byte or start result")
  `OPTF_ASSERT_IMPLIES(a_refuse_excl, clk, rst, !empty && load_refused, !tx_valid, "refused load carries a transmit byte")
  `OPTF_ASSERT_IMPLIES(a_idle_zero, clk, rst, !empty && !tx_valid, tx_byte == 8'd0 && !tx_start && !tx_last, "non-byte result has nonzero payload")
  `OPTF_ASSERT_NEXT(a_hold_head, clk, rst, !empty && !pop, !empty && $stable(tx_byte) && $stable(load_refused), "waiting result changed")

endmodule
